// ===== rtl/mcic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcic_pkg
// Types, codes and constants shared by the input capture core and its tests
// ----------------------------------------------------------------------------
package mcic_pkg;

	// default number of capture channels
	localparam int NUM_CHANNELS = 4;

	// width of the free-running counter feeding the capture inputs
	localparam int COUNTER_BITS = 16;

	// measurement keeps the low bits of the counter difference
	localparam int MEAS_BITS = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
	localparam logic [15:0] MEAS_MASK = 16'((32'd1 << MEAS_BITS) - 32'd1);

	// item opcodes
	typedef enum logic [1:0] {
		OP_CAPTURE = 2'd0,
		OP_ARM     = 2'd1,
		OP_STOP    = 2'd2,
		OP_READ    = 2'd3
	} opcode_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_IGNORED     = 2'd1,
		STAT_UNSUPPORTED = 2'd2,
		STAT_RSVD        = 2'd3
	} status_t;

	// per-channel capture modes
	typedef enum logic [1:0] {
		MODE_RISING  = 2'd0,
		MODE_FALLING = 2'd1,
		MODE_PULSE   = 2'd2,
		MODE_FREQ    = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CHANNEL_MODES = 2'd0,
		REG_ONE_SHOT_MASK = 2'd1,
		REG_AUTO_RELOAD   = 2'd2,
		REG_NONE          = 2'd3
	} cfg_reg_t;

	// input item
	typedef struct packed {
		opcode_t     opcode;
		logic [1:0]  channel;
		logic [15:0] captured_value;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [1:0]  result_channel;
		logic [15:0] measurement;
		logic        measurement_valid;
		status_t     status;
		logic        sense_falling;
		logic        channel_active;
	} res_t;

	// per-channel entry held in the state memory
	typedef struct packed {
		logic [15:0] previous_capture;
		logic        awaiting_falling;
		logic [15:0] last_measurement;
	} entry_t;

endpackage

// ===== rtl/mcic_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcic_ram
// Generic simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module mcic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/multi_channel_input_capture_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_input_capture_core
// Per-channel timer input capture: edge interval, pulse width, one-shot
//
//   channel | handshake           | payload                  | direction
//   --------+---------------------+--------------------------+----------
//   cmd     | cmd_valid/cmd_stall | cmd_t (opcode, channel,  | in
//           |                     | captured_value)          |
//   res     | res_valid/res_stall | res_t                    | out
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data      | in
//
// One item per cycle unless res stalls; each item gives one result in the
// output register after the update stage (state memory read, then update).
// Back-to-back items on the same channel are served by a write-forwarding
// register in front of the memory read data.
// Reset clears modes, one-shot mask, armed flags and entry valid bits, sets
// reload to FFFF; unwritten entries read as zero and need no clearing pass.
// A stalled output holds the update stage, which in turn stalls cmd.
// ----------------------------------------------------------------------------
module multi_channel_input_capture_core
	import mcic_pkg::*;
#(
	parameter int CHANNELS = NUM_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_reg_t    cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EW = $bits(entry_t);

	// counter difference wrapping through the reload value
	function automatic logic [15:0] wrap_diff(logic [15:0] now, logic [15:0] prev,
		logic [15:0] reload);
		logic [15:0] d;
		if (now >= prev) begin
			d = now - prev;
		end else begin
			d = reload - prev + now + 16'd1;
		end
		return d & MEAS_MASK;
	endfunction

	// configuration registers
	logic [7:0]  modes_q;
	logic [3:0]  single_mask_q;
	logic [15:0] reload_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q       <= '0;
			single_mask_q <= '0;
			reload_q      <= 16'hFFFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHANNEL_MODES: modes_q       <= cfg_data[7:0];
				REG_ONE_SHOT_MASK: single_mask_q <= cfg_data[3:0];
				REG_AUTO_RELOAD:   reload_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic   s1_valid_q;
	cmd_t   cmd_s1;
	logic   res_valid_q;
	res_t   res_q;
	logic   s1_adv;
	logic   s1_fire;
	logic   accept;

	assign s1_adv    = !res_valid_q || !res_stall;
	assign s1_fire   = s1_valid_q && s1_adv;
	assign cmd_stall = s1_valid_q && !s1_adv;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	// state memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [EW-1:0] ram_rdata;

	mcic_ram #(
		.WIDTH (EW),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (AW'(cmd.channel)),
		.rdata (ram_rdata)
	);

	// entry valid bits, armed flags and write forwarding
	logic [CHANNELS-1:0] vld_q;
	logic [CHANNELS-1:0] armed_q;
	logic                fwd_valid_q;
	logic [AW-1:0]       fwd_idx_q;
	entry_t              fwd_data_q;

	// update stage signals
	logic [AW-1:0] idx_s1;
	logic          in_range;
	logic          fwd_hit;
	entry_t        cur;
	entry_t        nxt;
	logic          armed_cur;
	logic          armed_nxt;
	logic          write_entry;
	mode_t         mode;
	logic          single_run;
	logic [15:0]   diff;
	res_t          res_next;

	assign idx_s1     = AW'(cmd_s1.channel);
	assign in_range   = int'(cmd_s1.channel) < CHANNELS;
	assign fwd_hit    = fwd_valid_q && (fwd_idx_q == idx_s1);
	assign mode       = mode_t'(modes_q[2*cmd_s1.channel +: 2]);
	assign single_run = single_mask_q[cmd_s1.channel];

	// current entry: latest write, else memory, else reset value
	always_comb begin
		if (!in_range) begin
			cur       = '0;
			armed_cur = 1'b0;
		end else begin
			armed_cur = armed_q[idx_s1];
			if (fwd_hit) begin
				cur = fwd_data_q;
			end else if (vld_q[idx_s1]) begin
				cur = entry_t'(ram_rdata);
			end else begin
				cur = '0;
			end
		end
	end

	assign diff = wrap_diff(cmd_s1.captured_value, cur.previous_capture, reload_q);

	// per-opcode update
	always_comb begin
		nxt         = cur;
		armed_nxt   = armed_cur;
		write_entry = 1'b0;
		res_next    = '0;
		res_next.result_channel = cmd_s1.channel;
		res_next.status         = STAT_OK;
		if (!in_range) begin
			res_next.status = STAT_IGNORED;
		end else begin
			case (cmd_s1.opcode)
				OP_CAPTURE: begin
					if (!armed_cur) begin
						res_next.status = STAT_IGNORED;
					end else if (mode == MODE_FREQ) begin
						res_next.status = STAT_UNSUPPORTED;
					end else if (mode inside {MODE_RISING, MODE_FALLING}) begin
						write_entry                = 1'b1;
						nxt.previous_capture       = cmd_s1.captured_value;
						nxt.last_measurement       = diff;
						res_next.measurement       = diff;
						res_next.measurement_valid = 1'b1;
					end else if (!cur.awaiting_falling) begin
						write_entry          = 1'b1;
						nxt.previous_capture = cmd_s1.captured_value;
						nxt.awaiting_falling = 1'b1;
					end else begin
						write_entry                = 1'b1;
						nxt.last_measurement       = diff;
						nxt.awaiting_falling       = 1'b0;
						res_next.measurement       = diff;
						res_next.measurement_valid = 1'b1;
					end
					if (res_next.measurement_valid && single_run) begin
						armed_nxt = 1'b0;
					end
				end
				OP_ARM: begin
					if (mode == MODE_FREQ) begin
						res_next.status = STAT_UNSUPPORTED;
					end else begin
						write_entry = 1'b1;
						nxt         = '0;
						armed_nxt   = 1'b1;
					end
				end
				OP_STOP: begin
					write_entry = 1'b1;
					nxt         = '0;
					armed_nxt   = 1'b0;
				end
				OP_READ: begin
					if (mode == MODE_FREQ) begin
						res_next.status = STAT_UNSUPPORTED;
					end else begin
						res_next.measurement = cur.last_measurement;
					end
				end
				default: ;
			endcase
			res_next.sense_falling  = nxt.awaiting_falling;
			res_next.channel_active = armed_nxt;
		end
	end

	assign ram_we    = s1_fire && write_entry;
	assign ram_waddr = idx_s1;
	assign ram_wdata = nxt;

	// valid bits, armed flags and forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			armed_q     <= '0;
			fwd_valid_q <= 1'b0;
		end else if (s1_fire && in_range) begin
			armed_q[idx_s1] <= armed_nxt;
			if (write_entry) begin
				vld_q[idx_s1] <= 1'b1;
				fwd_valid_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a completed measurement always carries ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.measurement_valid |-> res.status == STAT_OK)
		else $error("measurement reported with non-ok status");

	// input is only held off while the update stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> s1_valid_q)
		else $error("stall without an item in the update stage");

	// a write colliding with a read of the same entry is forwarded next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && accept && (ram_waddr == AW'(cmd.channel)) |=> fwd_hit)
		else $error("same-entry write and read not forwarded");

	// armed flag follows the reported channel_active
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && in_range |=> armed_q[$past(idx_s1)] == $past(res_next.channel_active))
		else $error("armed flag differs from reported channel_active");

endmodule
